// ===== rtl/core/tcos_pkg.sv =====
// Shared types and constants for the fixed-point Taylor cosine unit.
// Used by tcos_cell and taylor_cosine_fixed_point_unit; no dependencies.
package tcos_pkg;

    localparam int ANGLE_W  = 31;  // Q2.28 signed
    localparam int COS_W    = 32;  // Q1.30 signed
    localparam int MAG_W    = 31;  // |x|, at most 2^30
    localparam int SQ_W     = 34;  // x^2 >> 27, at most 2^33
    localparam int N_W      = 33;  // x^2 >> 28 plus half the divisor, for a rounded divide
    localparam int Q_W      = 32;  // x^2 / (i(i-1)) in Q.28
    localparam int TERM_W   = 36;  // term magnitude, Q.30
    localparam int ACC_W    = 38;  // running sum, signed Q.30
    localparam int RECIP_SH = 33;  // reciprocal scale

    localparam logic [TERM_W-1:0]        TERM_ONE = TERM_W'(64'd1 << 30);
    localparam logic signed [ACC_W-1:0]  ACC_ONE  = ACC_W'(64'd1 << 30);
    localparam logic signed [COS_W-1:0]  COS_ONE  = COS_W'(64'd1 << 30);

    typedef struct packed {
        logic                     vld;
        logic [SQ_W-1:0]          sq27;
        logic [TERM_W-1:0]        term;
        logic signed [ACC_W-1:0]  acc;
    } cos_lane_t;

endpackage

// ===== rtl/core/tcos_cell.sv =====
// One series cell: scales the incoming term by x^2/(i(i-1)) and folds it into the sum.
// Five registered stages; depends on tcos_pkg.
module tcos_cell #(
    parameter int ORDER = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  tcos_pkg::cos_lane_t lane_i,
    output tcos_pkg::cos_lane_t lane_o
);
    import tcos_pkg::*;

    localparam int D = ORDER * (ORDER - 1);
    localparam logic SUB = ((ORDER / 2) % 2) == 1;
    localparam logic [N_W-1:0] RECIP = N_W'((66'd1 << RECIP_SH) / 66'(D));

    cos_lane_t s1_lane_reg, s2_lane_reg, s3_lane_reg, s4_lane_reg, s5_lane_reg;
    logic [N_W-1:0]  s1_n_reg, s2_n_reg;
    logic [48:0]     s1_plo_reg, s1_plo_next;
    logic [49:0]     s1_phi_reg, s1_phi_next;
    logic [N_W-1:0]  s2_qe_reg, s2_qe_next;
    logic [Q_W-1:0]  s3_q_reg, s3_q_next;
    logic [49:0]     s4_pa_reg, s4_pa_next, s4_pb_reg, s4_pb_next;
    cos_lane_t       s5_lane_next;

    logic [N_W-1:0]  n_next;
    logic [65:0]     prod;
    logic [42:0]     qd, rem;
    logic [67:0]     tsum;
    logic [TERM_W-1:0] term_new;

    // bias x^2/2^28 by D/2 so that the divide rounds to nearest
    assign n_next      = N_W'((35'(lane_i.sq27) + 35'(D)) >> 1);
    assign s1_plo_next = 49'(n_next[15:0]) * 49'(RECIP);
    assign s1_phi_next = 50'(n_next[32:16]) * 50'(RECIP);

    assign prod       = (66'(s1_phi_reg) << 16) + 66'(s1_plo_reg);
    assign s2_qe_next = prod[65:33];

    // estimate is exact or one low
    assign qd  = 43'(s2_qe_reg) * 43'(D);
    assign rem = 43'(s2_n_reg) - qd;
    assign s3_q_next = (rem >= 43'(D)) ? Q_W'(s2_qe_reg + N_W'(1)) : Q_W'(s2_qe_reg);

    assign s4_pa_next = 50'(s3_lane_reg.term[17:0]) * 50'(s3_q_reg);
    assign s4_pb_next = 50'(s3_lane_reg.term[35:18]) * 50'(s3_q_reg);

    assign tsum     = (68'(s4_pb_reg) << 18) + 68'(s4_pa_reg) + (68'd1 << 27);
    assign term_new = tsum[63:28];

    always_comb begin
        s5_lane_next      = s4_lane_reg;
        s5_lane_next.term = term_new;
        if (SUB) begin
            s5_lane_next.acc = s4_lane_reg.acc - $signed({2'b00, term_new});
        end else begin
            s5_lane_next.acc = s4_lane_reg.acc + $signed({2'b00, term_new});
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_lane_reg.vld <= 1'b0;
            s2_lane_reg.vld <= 1'b0;
            s3_lane_reg.vld <= 1'b0;
            s4_lane_reg.vld <= 1'b0;
            s5_lane_reg.vld <= 1'b0;
        end else if (en) begin
            s1_lane_reg <= lane_i;
            s2_lane_reg <= s1_lane_reg;
            s3_lane_reg <= s2_lane_reg;
            s4_lane_reg <= s3_lane_reg;
            s5_lane_reg <= s5_lane_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_n_reg   <= n_next;
            s1_plo_reg <= s1_plo_next;
            s1_phi_reg <= s1_phi_next;
            s2_n_reg   <= s1_n_reg;
            s2_qe_reg  <= s2_qe_next;
            s3_q_reg   <= s3_q_next;
            s4_pa_reg  <= s4_pa_next;
            s4_pb_reg  <= s4_pb_next;
        end
    end

    assign lane_o = s5_lane_reg;

endmodule

// ===== rtl/core/taylor_cosine_fixed_point_unit.sv =====
// Fixed-point cosine: 1 plus MAX_ORDER/2 alternating Taylor terms, saturated to +/-1.0.
// Top level; instantiates tcos_cell and depends on tcos_pkg.
//
// Takes one request per cycle on s_ while s_tready is high (angle, signed Q2.28
// in [-4,4)) and returns cos(angle) as signed Q1.30 on m_, clamped to [-1.0, +1.0].
// The angle's magnitude and its square are registered, then come each series
// cell's stages and the saturating output register. The row of cells is fully
// pipelined, so throughput is one result per cycle while m_ is not stalled;
// results come out in request order. The pipeline keeps
// taking requests while a result waits on m_, until that next result reaches
// the final cell. Odd MAX_ORDER behaves as the next lower even order.
module taylor_cosine_fixed_point_unit #(
    parameter int MAX_ORDER = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] angle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] cosine
);
    import tcos_pkg::*;

    localparam int NCELL = MAX_ORDER / 2;

    cos_lane_t chain [NCELL+1];
    cos_lane_t last;

    logic              en, out_load;
    logic [ANGLE_W-1:0] angle;
    logic              f1_vld_reg;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [61:0]       sq;
    cos_lane_t         f2_lane_reg, f2_lane_next;
    logic              m_tvalid_reg;
    logic [COS_W-1:0]  m_tdata_reg, sat;

    assign last     = chain[NCELL];
    assign out_load = last.vld && (!m_tvalid_reg || m_tready);
    assign en       = !last.vld || out_load;
    assign s_tready = en;

    assign angle    = s_tdata[ANGLE_W-1:0];
    assign mag_next = angle[ANGLE_W-1] ? (~angle + MAG_W'(1)) : angle;
    assign sq       = 62'(mag_reg) * 62'(mag_reg);

    always_comb begin
        f2_lane_next.vld  = f1_vld_reg;
        f2_lane_next.sq27 = sq[60:27];
        f2_lane_next.term = TERM_ONE;
        f2_lane_next.acc  = ACC_ONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg      <= 1'b0;
            f2_lane_reg.vld <= 1'b0;
        end else if (en) begin
            f1_vld_reg  <= s_tvalid;
            f2_lane_reg <= f2_lane_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg <= mag_next;
        end
    end

    assign chain[0] = f2_lane_reg;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        tcos_cell #(
            .ORDER(2 * (k + 1))
        ) u_cell (
            .aclk   (aclk),
            .aresetn(aresetn),
            .en     (en),
            .lane_i (chain[k]),
            .lane_o (chain[k+1])
        );
    end

    always_comb begin
        if (last.acc > ACC_ONE) begin
            sat = COS_ONE;
        end else if (last.acc < -ACC_ONE) begin
            sat = -COS_ONE;
        end else begin
            sat = last.acc[COS_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= sat;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // result never leaves the saturation window
    a_sat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(m_tdata) <= COS_ONE && $signed(m_tdata) >= -COS_ONE))
        else $error("cosine outside +/-1.0");

    // requests are refused only behind a held result with the last cell full
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid_reg && !m_tready && last.vld))
        else $error("request refused without a held result");

    // a finished item in the last cell is moved to the output when it advances
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (en && last.vld) |=> m_tvalid_reg)
        else $error("result dropped from last cell");

endmodule
